// File: src/safa_pkg.sv
// Package for the surface anisotropy field accumulator.
// Holds the sequencer state type, the control bundle, step numbers and
// configuration register indexes. No dependencies.
package safa_pkg;

    localparam int STEP_W = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_PUSH
    } state_t;

    // Sequencer steps. A product issued at one step is consumed at the next.
    localparam logic [STEP_W-1:0] STEP_IX   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_IY   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_IZ   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_DOT  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_NX   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_NY   = 4'd5;
    localparam logic [STEP_W-1:0] STEP_NZ   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_DD   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_FX   = 4'd8;
    localparam logic [STEP_W-1:0] STEP_FY   = 4'd9;
    localparam logic [STEP_W-1:0] STEP_FZ   = 4'd10;
    localparam logic [STEP_W-1:0] STEP_EN   = 4'd11;
    localparam logic [STEP_W-1:0] STEP_LAST = 4'd12;

    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFACTOR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYERS     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_EN    = 3'd6;

    typedef struct packed {
        logic              accept;
        logic              calc;
        logic [STEP_W-1:0] step;
        logic              load;
    } ctrl_t;

endpackage

// File: src/safa_if.sv
// Handshake interfaces for the cell, result and configuration channels.
// Depends on safa_pkg for the configuration port widths.
interface safa_cell_if;
    logic               valid;
    logic               ready;
    logic        [9:0]  cell_x;
    logic        [9:0]  cell_y;
    logic        [9:0]  cell_z;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
    logic signed [31:0] field_in_x;
    logic signed [31:0] field_in_y;
    logic signed [31:0] field_in_z;
    logic        [2:0]  mask_bits;
    logic               last_cell;

    modport source (
        output valid, cell_x, cell_y, cell_z, mag_x, mag_y, mag_z,
               field_in_x, field_in_y, field_in_z, mask_bits, last_cell,
        input  ready
    );
    modport sink (
        input  valid, cell_x, cell_y, cell_z, mag_x, mag_y, mag_z,
               field_in_x, field_in_y, field_in_z, mask_bits, last_cell,
        output ready
    );
endinterface

interface safa_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] field_out_x;
    logic signed [31:0] field_out_y;
    logic signed [31:0] field_out_z;
    logic               surface_hit;
    logic signed [63:0] energy_total;
    logic               sweep_done;

    modport source (
        output valid, field_out_x, field_out_y, field_out_z, surface_hit,
               energy_total, sweep_done,
        input  ready
    );
    modport sink (
        input  valid, field_out_x, field_out_y, field_out_z, surface_hit,
               energy_total, sweep_done,
        output ready
    );
endinterface

interface safa_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [safa_pkg::CFG_IDX_W-1:0]     index;
    logic [safa_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: src/safa_mul.sv
// Shared signed 32 x 32 multiplier with a registered product.
// Depends on nothing but the clock; operands are chosen by the caller.
module safa_mul (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [63:0] p
);

    logic signed [63:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= 64'(a) * 64'(b);
        end
    end

    assign p = p_reg;

endmodule

// File: src/safa_ctrl.sv
// Sequencer for the accumulator: accepts a cell, steps the shared
// multiplier through its schedule and hands the result to the output stage.
// Depends on safa_pkg.
module safa_ctrl
    import safa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  hit_now,
    input  logic  out_free,
    output logic  in_ready,
    output ctrl_t ctrl
);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_IX;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        in_ready    = 1'b0;
        ctrl.accept = 1'b0;
        ctrl.calc   = 1'b0;
        ctrl.step   = step_reg;
        ctrl.load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                step_next = STEP_IX;
                if (in_valid)
                begin
                    ctrl.accept = 1'b1;
                    // Cells off the surface skip the arithmetic entirely.
                    state_next  = hit_now ? ST_CALC : ST_PUSH;
                end
            end
            ST_CALC:
            begin
                ctrl.calc = 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_PUSH;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_PUSH:
            begin
                if (out_free)
                begin
                    ctrl.load  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_step_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CALC |-> step_reg <= STEP_LAST)
        else $error("sequencer step ran past the schedule");

    a_calc_to_push: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC && step_reg == STEP_LAST) |=> state_reg == ST_PUSH)
        else $error("last step did not lead to the output stage");

endmodule

// File: src/surface_anisotropy_field_accumulator_unit.sv
// Surface anisotropy field accumulator, top level with datapath and registers.
// A surface cell runs through 13 multiplier steps from request to result;
// other cells skip them. One cell is in work at a time; the result register
// lets the next cell start while a result waits. rst_n clears control,
// configuration to its defaults and the energy sum. Depends on safa_pkg,
// the safa interfaces, safa_ctrl and safa_mul.
module surface_anisotropy_field_accumulator_unit
    import safa_pkg::*;
#(
    parameter int GRID_MAX = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    safa_cfg_if.sink   cfg,
    safa_cell_if.sink  cells,
    safa_res_if.source result
);

    localparam int LW = $clog2(GRID_MAX + 1);
    localparam int CW = (LW > 11 ? LW : 11) + 1;

    // Configuration registers
    logic signed [15:0] normal_x_reg, normal_y_reg, normal_z_reg;
    logic signed [31:0] prefactor_reg, weight_reg;
    logic        [10:0] layers_reg;
    logic               mask_en_reg;

    // Working registers for the cell in progress
    logic signed [15:0] mag_x_reg, mag_y_reg, mag_z_reg;
    logic signed [31:0] fld_x_reg, fld_y_reg, fld_z_reg;
    logic               hit_reg, last_reg;
    logic signed [33:0] acc_reg;
    logic signed [15:0] dot_reg;
    logic signed [31:0] tx_reg, ty_reg, tz_reg, dd_reg;
    logic signed [63:0] energy_reg;

    // Result register
    logic               res_valid_reg;
    logic signed [31:0] out_x_reg, out_y_reg, out_z_reg;
    logic               out_hit_reg, out_done_reg;
    logic signed [63:0] out_energy_reg;

    ctrl_t              ctrl;
    logic               hit_now;
    logic               out_free;
    logic signed [31:0] op_a, op_b;
    logic signed [63:0] prod;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111)
        begin
            return v[31:0];
        end
        return v[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

    function automatic logic signed [31:0] sx16(input logic signed [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // ---------------- surface test at request time ----------------
    logic [16:0]   abs_x, abs_y, abs_z;
    logic [9:0]    coord;
    logic [CW-1:0] layers_ext, layers_clamp, coord_ext;
    logic          lower_out, upper_out;

    always_comb
    begin
        abs_x = normal_x_reg[15] ? 17'(-sx16(normal_x_reg)) : 17'(normal_x_reg);
        abs_y = normal_y_reg[15] ? 17'(-sx16(normal_y_reg)) : 17'(normal_y_reg);
        abs_z = normal_z_reg[15] ? 17'(-sx16(normal_z_reg)) : 17'(normal_z_reg);
        if (abs_z >= abs_y && abs_z >= abs_x)
        begin
            coord = cells.cell_z;
        end
        else if (abs_y >= abs_x)
        begin
            coord = cells.cell_y;
        end
        else
        begin
            coord = cells.cell_x;
        end
        layers_ext = CW'(layers_reg);
        if (layers_reg == 11'd0)
        begin
            layers_clamp = CW'(1);
        end
        else if (layers_ext > CW'(GRID_MAX))
        begin
            layers_clamp = CW'(GRID_MAX);
        end
        else
        begin
            layers_clamp = layers_ext;
        end
        coord_ext = CW'(coord);
        lower_out = (coord == 10'd0) || !cells.mask_bits[1];
        upper_out = (coord_ext + CW'(1) >= layers_clamp) || !cells.mask_bits[2];
        if (mask_en_reg)
        begin
            hit_now = cells.mask_bits[0] && (lower_out || upper_out);
        end
        else
        begin
            hit_now = (coord == 10'd0) || (coord_ext == layers_clamp - CW'(1));
        end
    end

    // ---------------- configuration port ----------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_x_reg  <= 16'sd0;
            normal_y_reg  <= 16'sd0;
            normal_z_reg  <= 16'sd16384;
            prefactor_reg <= 32'sd0;
            weight_reg    <= 32'sd0;
            layers_reg    <= 11'd1;
            mask_en_reg   <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_NORMAL_X:  normal_x_reg  <= cfg.data[15:0];
                CFG_NORMAL_Y:  normal_y_reg  <= cfg.data[15:0];
                CFG_NORMAL_Z:  normal_z_reg  <= cfg.data[15:0];
                CFG_PREFACTOR: prefactor_reg <= cfg.data;
                CFG_WEIGHT:    weight_reg    <= cfg.data;
                CFG_LAYERS:    layers_reg    <= cfg.data[10:0];
                CFG_MASK_EN:   mask_en_reg   <= cfg.data[0];
                default:       ;
            endcase
        end
    end

    // ---------------- sequencer and shared multiplier ----------------
    assign out_free = !res_valid_reg || result.ready;

    safa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cells.valid),
        .hit_now  (hit_now),
        .out_free (out_free),
        .in_ready (cells.ready),
        .ctrl     (ctrl)
    );

    always_comb
    begin
        op_a = 32'sd0;
        op_b = 32'sd0;
        case (ctrl.step)
            STEP_IX: begin op_a = sx16(mag_x_reg); op_b = sx16(normal_x_reg); end
            STEP_IY: begin op_a = sx16(mag_y_reg); op_b = sx16(normal_y_reg); end
            STEP_IZ: begin op_a = sx16(mag_z_reg); op_b = sx16(normal_z_reg); end
            STEP_NX: begin op_a = sx16(dot_reg);   op_b = sx16(normal_x_reg); end
            STEP_NY: begin op_a = sx16(dot_reg);   op_b = sx16(normal_y_reg); end
            STEP_NZ: begin op_a = sx16(dot_reg);   op_b = sx16(normal_z_reg); end
            STEP_DD: begin op_a = sx16(dot_reg);   op_b = sx16(dot_reg);      end
            STEP_FX: begin op_a = prefactor_reg;   op_b = tx_reg;             end
            STEP_FY: begin op_a = prefactor_reg;   op_b = ty_reg;             end
            STEP_FZ: begin op_a = prefactor_reg;   op_b = tz_reg;             end
            STEP_EN: begin op_a = weight_reg;      op_b = dd_reg;             end
            default: ;
        endcase
    end

    safa_mul u_mul (
        .clk (clk),
        .en  (ctrl.calc),
        .a   (op_a),
        .b   (op_b),
        .p   (prod)
    );

    // ---------------- consumers of the registered product ----------------
    logic signed [33:0] dot_sum;
    logic signed [19:0] dot_sh;
    logic signed [15:0] dot_sat;
    logic signed [35:0] fld_sum;
    logic signed [31:0] fld_sel;
    logic signed [64:0] en_sum;
    logic signed [63:0] en_term;
    logic signed [63:0] en_sat;

    always_comb
    begin
        dot_sum = acc_reg + prod[33:0];
        // Arithmetic shift by 14 rounds toward minus infinity.
        dot_sh  = dot_sum[33:14];
        if (dot_sh[19:15] == 5'b00000 || dot_sh[19:15] == 5'b11111)
        begin
            dot_sat = dot_sh[15:0];
        end
        else
        begin
            dot_sat = dot_sh[19] ? 16'sh8000 : 16'sh7FFF;
        end

        // The field term for an axis arrives one step after it was issued.
        case (ctrl.step)
            STEP_FZ: fld_sel = fld_y_reg;
            STEP_EN: fld_sel = fld_z_reg;
            default: fld_sel = fld_x_reg;
        endcase
        fld_sum = {{4{fld_sel[31]}}, fld_sel} + {prod[63], prod[63:29]};

        en_term = {{30{prod[63]}}, prod[63:30]};
        en_sum  = {energy_reg[63], energy_reg} + {en_term[63], en_term};
        if (en_sum[64] != en_sum[63])
        begin
            en_sat = en_sum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        else
        begin
            en_sat = en_sum[63:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            mag_x_reg <= cells.mag_x;
            mag_y_reg <= cells.mag_y;
            mag_z_reg <= cells.mag_z;
            fld_x_reg <= cells.field_in_x;
            fld_y_reg <= cells.field_in_y;
            fld_z_reg <= cells.field_in_z;
            hit_reg   <= hit_now;
            last_reg  <= cells.last_cell;
        end
        else if (ctrl.calc)
        begin
            // Each write-back takes the product issued one step earlier.
            case (ctrl.step)
                STEP_IY:  acc_reg   <= prod[33:0];
                STEP_IZ:  acc_reg   <= dot_sum;
                STEP_DOT: dot_reg   <= dot_sat;
                STEP_NY:  tx_reg    <= prod[31:0];
                STEP_NZ:  ty_reg    <= prod[31:0];
                STEP_DD:  tz_reg    <= prod[31:0];
                STEP_FX:  dd_reg    <= prod[31:0];
                STEP_FY:  fld_x_reg <= sat32(fld_sum);
                STEP_FZ:  fld_y_reg <= sat32(fld_sum);
                STEP_EN:  fld_z_reg <= sat32(fld_sum);
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_reg <= 64'sd0;
        end
        else if (ctrl.calc && ctrl.step == STEP_LAST)
        begin
            energy_reg <= en_sat;
        end
        else if (ctrl.load && last_reg)
        begin
            energy_reg <= 64'sd0;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            out_x_reg      <= fld_x_reg;
            out_y_reg      <= fld_y_reg;
            out_z_reg      <= fld_z_reg;
            out_hit_reg    <= hit_reg;
            out_done_reg   <= last_reg;
            out_energy_reg <= last_reg ? energy_reg : 64'sd0;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.field_out_x  = out_x_reg;
    assign result.field_out_y  = out_y_reg;
    assign result.field_out_z  = out_z_reg;
    assign result.surface_hit  = out_hit_reg;
    assign result.energy_total = out_energy_reg;
    assign result.sweep_done   = out_done_reg;

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        (cells.valid && cells.ready) |=> !cells.ready)
        else $error("a second request was taken while a cell was in work");

    a_result_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(ctrl.load))
        else $error("result appeared without a load from the sequencer");

    a_energy_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.sweep_done) |-> result.energy_total == 64'sd0)
        else $error("energy shown on a result that does not end the sweep");

    a_energy_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.load && last_reg) |=> energy_reg == 64'sd0)
        else $error("energy sum not cleared after the last cell");

endmodule

// File: sim/surface_anisotropy_field_accumulator_unit_test.sv
// Self-checking bench for the surface anisotropy field accumulator: directed
// extremes, back-pressure and random sweeps, checked against an in-bench model.
// Depends on safa_pkg, the safa interfaces and the top level of the block.
`timescale 1ns / 1ps

module surface_anisotropy_field_accumulator_unit_test;
    import safa_pkg::*;

    localparam longint LAYER_LIMIT = 1024;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef enum int { AXIS_X, AXIS_Y, AXIS_Z } axis_t;

    typedef struct {
        logic        [9:0]  cell_x;
        logic        [9:0]  cell_y;
        logic        [9:0]  cell_z;
        logic signed [15:0] mag_x;
        logic signed [15:0] mag_y;
        logic signed [15:0] mag_z;
        logic signed [31:0] field_in_x;
        logic signed [31:0] field_in_y;
        logic signed [31:0] field_in_z;
        logic        [2:0]  mask_bits;
        logic               last_cell;
    } cell_t;

    typedef struct {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fz;
        logic               hit;
        logic signed [63:0] energy;
        logic               done;
    } surface_result_t;

    logic clk;
    logic rst_n;

    safa_cfg_if  cfg ();
    safa_cell_if cells ();
    safa_res_if  result ();

    surface_anisotropy_field_accumulator_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .cells  (cells),
        .result (result)
    );

    // Shadow copy of the configuration and the running energy.
    logic signed [15:0] nrm_x;
    logic signed [15:0] nrm_y;
    logic signed [15:0] nrm_z;
    logic signed [31:0] prefactor;
    logic signed [31:0] weight;
    logic        [10:0] layers;
    logic               mask_on;
    logic signed [63:0] energy_acc;

    surface_result_t pending_results[$];
    int              error_count = 0;
    bit              steady = 1'b0;
    int unsigned     result_hold = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint magnitude(input logic signed [15:0] v);
        return (v < 0) ? -longint'(v) : longint'(v);
    endfunction

    function automatic axis_t dominant_axis();
        longint ax;
        longint ay;
        longint az;
        ax = magnitude(nrm_x);
        ay = magnitude(nrm_y);
        az = magnitude(nrm_z);
        if (az >= ay && az >= ax)
            return AXIS_Z;
        else if (ay >= ax)
            return AXIS_Y;
        return AXIS_X;
    endfunction

    function automatic longint effective_layers();
        longint len;
        len = longint'(layers);
        if (len < 1)
            len = 1;
        if (len > LAYER_LIMIT)
            len = LAYER_LIMIT;
        return len;
    endfunction

    function automatic logic signed [31:0] sat32(input longint v);
        if (v > 64'sh7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        if (v < -64'sh8000_0000)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Works out the result of one accepted cell and updates the energy sum.
    task automatic predict_surface_cell(input cell_t c);
        longint          lc;
        longint          len;
        longint          dot;
        longint          pd;
        longint          e;
        logic signed [64:0] sum;
        bit              hit;
        bit              lower_out;
        bit              upper_out;
        surface_result_t r;
        case (dominant_axis())
            AXIS_X:  lc = longint'(c.cell_x);
            AXIS_Y:  lc = longint'(c.cell_y);
            default: lc = longint'(c.cell_z);
        endcase
        len = effective_layers();
        if (mask_on)
        begin
            lower_out = (lc == 0) || !c.mask_bits[1];
            upper_out = (lc + 1 >= len) || !c.mask_bits[2];
            hit = c.mask_bits[0] && (lower_out || upper_out);
        end
        else
            hit = (lc == 0) || (lc == len - 1);
        r.fx = c.field_in_x;
        r.fy = c.field_in_y;
        r.fz = c.field_in_z;
        if (hit)
        begin
            dot = longint'(c.mag_x) * longint'(nrm_x) + longint'(c.mag_y) * longint'(nrm_y)
                + longint'(c.mag_z) * longint'(nrm_z);
            dot = dot >>> 14;
            if (dot > 32767)
                dot = 32767;
            if (dot < -32768)
                dot = -32768;
            pd = longint'(prefactor) * dot;
            r.fx = sat32(longint'(c.field_in_x) + ((pd * longint'(nrm_x)) >>> 29));
            r.fy = sat32(longint'(c.field_in_y) + ((pd * longint'(nrm_y)) >>> 29));
            r.fz = sat32(longint'(c.field_in_z) + ((pd * longint'(nrm_z)) >>> 29));
            e = (longint'(weight) * (dot * dot)) >>> 30;
            sum = {energy_acc[63], energy_acc} + {e[63], e};
            if (sum[64] != sum[63])
                energy_acc = sum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
            else
                energy_acc = sum[63:0];
        end
        r.hit = hit;
        r.done = c.last_cell;
        r.energy = c.last_cell ? energy_acc : 64'sd0;
        if (c.last_cell)
            energy_acc = 64'sd0;
        pending_results.push_back(r);
    endtask

    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        case (idx)
            CFG_NORMAL_X:  nrm_x = data[15:0];
            CFG_NORMAL_Y:  nrm_y = data[15:0];
            CFG_NORMAL_Z:  nrm_z = data[15:0];
            CFG_PREFACTOR: prefactor = data;
            CFG_WEIGHT:    weight = data;
            CFG_LAYERS:    layers = data[10:0];
            CFG_MASK_EN:   mask_on = data[0];
            default:       ;
        endcase
    endtask

    // Leaves valid high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge clk); while (!cfg.ready);
        apply_register(idx, data);
    endtask

    task automatic wait_for_results();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic configure(input logic [31:0] nx, input logic [31:0] ny,
                             input logic [31:0] nz, input logic [31:0] pf,
                             input logic [31:0] w, input logic [31:0] lay,
                             input logic [31:0] men);
        wait_for_results();
        write_reg(CFG_NORMAL_X, nx);
        write_reg(CFG_NORMAL_Y, ny);
        write_reg(CFG_NORMAL_Z, nz);
        write_reg(CFG_PREFACTOR, pf);
        write_reg(CFG_WEIGHT, w);
        write_reg(CFG_LAYERS, lay);
        write_reg(CFG_MASK_EN, men);
        cfg.valid <= 1'b0;
    endtask

    // Offers one cell and waits for its request to be taken. Valid stays
    // high unless a random gap follows, so back-to-back requests are possible.
    task automatic send_cell(input cell_t c);
        cells.valid      <= 1'b1;
        cells.cell_x     <= c.cell_x;
        cells.cell_y     <= c.cell_y;
        cells.cell_z     <= c.cell_z;
        cells.mag_x      <= c.mag_x;
        cells.mag_y      <= c.mag_y;
        cells.mag_z      <= c.mag_z;
        cells.field_in_x <= c.field_in_x;
        cells.field_in_y <= c.field_in_y;
        cells.field_in_z <= c.field_in_z;
        cells.mask_bits  <= c.mask_bits;
        cells.last_cell  <= c.last_cell;
        do @(posedge clk); while (!cells.ready);
        predict_surface_cell(c);
        if (!steady && $urandom_range(99) < 33)
        begin
            cells.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    function automatic cell_t cell_at(input int x, input int y, input int z, input int mx,
                                      input int my, input int mz, input int fx,
                                      input int fy, input int fz, input int mask,
                                      input bit last);
        cell_t c;
        c.cell_x = 10'(x);
        c.cell_y = 10'(y);
        c.cell_z = 10'(z);
        c.mag_x = 16'(mx);
        c.mag_y = 16'(my);
        c.mag_z = 16'(mz);
        c.field_in_x = fx;
        c.field_in_y = fy;
        c.field_in_z = fz;
        c.mask_bits = 3'(mask);
        c.last_cell = last;
        return c;
    endfunction

    function automatic logic signed [15:0] random_mag();
        case ($urandom_range(9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [31:0] random_field();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF - 32'($urandom_range(1000));
            1:       return 32'h8000_0000 + 32'($urandom_range(1000));
            default: return 32'($urandom);
        endcase
    endfunction

    // Cells are placed mostly on the first and last layer so that the
    // surface path is taken often.
    function automatic cell_t make_cell(input bit last);
        cell_t      c;
        longint     len;
        logic [9:0] along;
        int         pick;
        len = effective_layers();
        c.cell_x = 10'($urandom);
        c.cell_y = 10'($urandom);
        c.cell_z = 10'($urandom);
        pick = $urandom_range(9);
        if (pick < 4)
            along = 10'd0;
        else if (pick < 8)
            along = 10'(len - 1);
        else if (pick == 8)
            along = 10'($urandom_range(32'(len + 1)));
        else
            along = 10'($urandom);
        case (dominant_axis())
            AXIS_X:  c.cell_x = along;
            AXIS_Y:  c.cell_y = along;
            default: c.cell_z = along;
        endcase
        c.mag_x = random_mag();
        c.mag_y = random_mag();
        c.mag_z = random_mag();
        c.field_in_x = random_field();
        c.field_in_y = random_field();
        c.field_in_z = random_field();
        c.mask_bits = 3'($urandom);
        c.last_cell = last;
        return c;
    endfunction

    function automatic logic [31:0] random_component();
        return 32'(int'($urandom_range(32768)) - 16384);
    endfunction

    function automatic logic [31:0] random_wide();
        case ($urandom_range(5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'($urandom_range(65536)) - 32'd32768;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] random_layers();
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return 32'($urandom_range(1, 8));
            6:                return 32'($urandom_range(9, 64));
            7:                return 32'd1024;
            8:                return 32'($urandom_range(1025, 2047)) & {32{$urandom_range(3) != 0}};
            default:          return $urandom;
        endcase
    endfunction

    task automatic random_phase(input int n_items);
        logic [31:0] nx;
        logic [31:0] ny;
        logic [31:0] nz;
        int          v;
        int          sweep_left;
        bit          last;
        nx = random_component();
        ny = random_component();
        nz = random_component();
        case ($urandom_range(4))
            0:
            begin
                nx = 32'd0;
                ny = 32'd0;
                nz = 32'd0;
                case ($urandom_range(2))
                    0:       nx = $urandom_range(1) ? 32'd16384 : -32'sd16384;
                    1:       ny = $urandom_range(1) ? 32'd16384 : -32'sd16384;
                    default: nz = $urandom_range(1) ? 32'd16384 : -32'sd16384;
                endcase
            end
            1:
            begin
                nx = 32'd0;
                ny = 32'd0;
                nz = 32'd0;
            end
            2:
            begin
                // Equal magnitudes on two or three axes exercise the tie order.
                v = $urandom_range(1, 16384);
                nx = $urandom_range(1) ? 32'(v) : 32'(-v);
                ny = $urandom_range(1) ? 32'(v) : 32'(-v);
                if ($urandom_range(1))
                    nz = $urandom_range(1) ? 32'(v) : 32'(-v);
                else
                    nz = 32'($urandom_range(32'(v - 1)));
            end
            3:
            begin
                nx = $urandom;
                ny = $urandom;
                nz = $urandom;
            end
            default: ;
        endcase
        configure(nx, ny, nz, random_wide(), random_wide(), random_layers(),
                  $urandom_range(1) ? $urandom : 32'($urandom_range(1)));
        sweep_left = $urandom_range(1, 24);
        for (int i = 0; i < n_items; i++)
        begin
            sweep_left--;
            last = (sweep_left == 0) || ($urandom_range(99) < 3);
            if (last)
                sweep_left = $urandom_range(1, 24);
            send_cell(make_cell(last));
        end
        cells.valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_cell(cell_at(17, 900, 0, 32767, -32768, 32767, 5, -5, 100, 7, 1'b0));
        send_cell(cell_at(0, 0, 1023, -32768, 32767, -32768, -1, 1, 2, 0, 1'b1));
        cells.valid <= 1'b0;
    endtask

    task automatic test_directed_extremes();
        // Largest terms of both signs with the field pushed into saturation.
        configure(32'd0, 32'd0, 32'd16384, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1024, 32'd0);
        send_cell(cell_at(1023, 1023, 0, 32767, 32767, 32767,
                          32'h7FFF_FF00, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1'b0));
        send_cell(cell_at(0, 0, 1023, -32768, -32768, -32768,
                          32'h8000_0100, 32'h7FFF_FFFF, 32'h8000_0000, 7, 1'b0));
        send_cell(cell_at(0, 1023, 500, 100, 200, 300, 1, 2, 3, 7, 1'b0));
        send_cell(cell_at(512, 256, 1023, 0, 0, -32768, 0, 0, 0, 5, 1'b1));
        cells.valid <= 1'b0;

        // Mask mode along x with a zero extent, which is taken as one layer.
        configure(-32'sd16384, 32'd8000, 32'd8000, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd1);
        send_cell(cell_at(0, 1023, 1023, -32768, 32767, 1, 32'h7FFF_FFFF, 0, 0, 1, 1'b0));
        send_cell(cell_at(0, 5, 5, 32767, 0, 0, 32'h8000_0000, 0, 0, 7, 1'b0));
        send_cell(cell_at(0, 5, 5, 32767, 0, 0, 0, 0, 0, 6, 1'b0));
        send_cell(cell_at(0, 5, 5, 32767, 0, 0, 0, 0, 0, 0, 1'b0));
        // Coordinates beyond the extent see an off-grid upper neighbour.
        send_cell(cell_at(5, 0, 0, -32768, -32768, 0, 10, 10, 10, 7, 1'b0));
        send_cell(cell_at(5, 0, 0, -32768, -32768, 0, 10, 10, 10, 6, 1'b1));
        cells.valid <= 1'b0;

        // Zero normal and an oversize extent; the mask bits are ignored.
        configure(32'd0, 32'd0, 32'd0, 32'h1234_5678, 32'h7654_3210, 32'd2047, 32'd0);
        write_reg(CFG_UNUSED, $urandom);
        cfg.valid <= 1'b0;
        send_cell(cell_at(1, 2, 1023, 32767, 32767, 32767, 7, 8, 9, 0, 1'b0));
        send_cell(cell_at(1, 2, 0, 32767, 32767, 32767, 7, 8, 9, 6, 1'b0));
        send_cell(cell_at(1, 2, 3, 32767, 32767, 32767, 7, 8, 9, 1, 1'b1));
        cells.valid <= 1'b0;

        // Equal magnitudes on all three axes go to z.
        configure(-32'sd9459, -32'sd9459, -32'sd9459, 32'd4000000, -32'sd3000000, 32'd2, 32'd0);
        send_cell(cell_at(700, 700, 0, 20000, -20000, 30000, 0, 0, 0, 0, 1'b0));
        send_cell(cell_at(0, 0, 1, -30000, 10000, 30000, 0, 0, 0, 0, 1'b1));
        cells.valid <= 1'b0;

        // A tie between x and y with a small z goes to y.
        configure(32'd9000, 32'd9000, 32'd100, 32'd4000000, 32'd3000000, 32'd2, 32'd0);
        send_cell(cell_at(5, 0, 5, 12000, 12000, 12000, 0, 0, 0, 0, 1'b0));
        send_cell(cell_at(0, 1, 0, -12000, 12000, 32767, 0, 0, 0, 0, 1'b1));
        cells.valid <= 1'b0;
    endtask

    // The receiver holds off while requests keep coming, so the block fills
    // up and stalls its input; then the sender waits for every result.
    task automatic test_backpressure();
        configure(32'd0, 32'd0, 32'd16384, random_wide(), random_wide(), 32'd4, 32'd0);
        steady = 1'b1;
        result_hold = 300;
        for (int i = 0; i < 40; i++)
            send_cell(make_cell(i == 39));
        cells.valid <= 1'b0;
        wait_for_results();
        steady = 1'b0;
    endtask

    task automatic test_random_sweeps();
        for (int phase = 0; phase < 10; phase++)
        begin
            steady = (phase == 3);
            random_phase(90);
        end
        steady = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (result_hold != 0)
        begin
            result.ready <= 1'b0;
            result_hold--;
        end
        else if (steady)
            result.ready <= 1'b1;
        else
            result.ready <= ($urandom_range(99) >= 33);
    end

    function automatic void check_field(input string name, input logic signed [63:0] want,
                                        input logic signed [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        surface_result_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("field_out_x", want.fx, result.field_out_x);
                check_field("field_out_y", want.fy, result.field_out_y);
                check_field("field_out_z", want.fz, result.field_out_z);
                check_field("surface_hit", want.hit, result.surface_hit);
                check_field("energy_total", want.energy, result.energy_total);
                check_field("sweep_done", want.done, result.sweep_done);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        nrm_x = 16'sd0;
        nrm_y = 16'sd0;
        nrm_z = 16'sd16384;
        prefactor = 32'sd0;
        weight = 32'sd0;
        layers = 11'd1;
        mask_on = 1'b0;
        energy_acc = 64'sd0;
        rst_n <= 1'b0;
        cfg.valid <= 1'b0;
        cfg.index <= '0;
        cfg.data <= '0;
        cells.valid <= 1'b0;
        cells.cell_x <= '0;
        cells.cell_y <= '0;
        cells.cell_z <= '0;
        cells.mag_x <= '0;
        cells.mag_y <= '0;
        cells.mag_z <= '0;
        cells.field_in_x <= '0;
        cells.field_in_y <= '0;
        cells.field_in_z <= '0;
        cells.mask_bits <= '0;
        cells.last_cell <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed_extremes();
        test_backpressure();
        test_random_sweeps();

        wait_for_results();
        repeat (40) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
